>>> rtl/i2cras_pkg.sv
// Shared types and constants for the I2C register access sequencer.
// No dependencies; imported by i2c_register_access_sequencer_core.
`timescale 1ns / 1ps

package i2cras_pkg;

	localparam logic [7:0] STATUS_MASK = 8'hF8;
	localparam logic [7:0] ADDR_W_MASK = 8'hFE;
	localparam logic [7:0] WRITE_OK    = 8'hFF;

	localparam logic [7:0] CODE_START  = 8'h08;
	localparam logic [7:0] CODE_RSTART = 8'h10;
	localparam logic [7:0] CODE_AW_ACK = 8'h18;
	localparam logic [7:0] CODE_B_ACK  = 8'h28;
	localparam logic [7:0] CODE_AR_ACK = 8'h40;

	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);

	typedef enum logic [2:0] {
		ACT_START = 3'd0,
		ACT_SEND  = 3'd1,
		ACT_READ  = 3'd2,
		ACT_STOP  = 3'd3,
		ACT_DONE  = 3'd4
	} action_t;

	typedef enum logic {
		KIND_REQUEST = 1'b0,
		KIND_EVENT   = 1'b1
	} kind_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] tx_byte;
		logic [7:0] result_value;
		logic       failed;
		logic [7:0] status_seen;
		logic       last;
	} result_t;

endpackage

>>> rtl/i2c_register_access_sequencer_core.sv
// I2C master register read/write sequencer: input register, phase logic,
// four-word result queue. Depends on i2cras_pkg.
// A word taken passes through the input register and is written into the result
// queue, whose head drives the result port. Throughput: one input word per cycle while
// the queue has room for two words; a word that yields two results needs the result
// port to take both of them, so the result port sets the sustained rate.
// Reset (arst_n low, asynchronous): phase idle, held bytes, status and
// slave_address cleared, input stage and result queue emptied.
`timescale 1ns / 1ps

module i2c_register_access_sequencer_core
	import i2cras_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	// input words
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic       write_not_read,
	input  logic [7:0] register_byte,
	input  logic [7:0] data_byte,
	input  logic [7:0] bus_status,
	input  logic [7:0] received_byte,
	// result words
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] action,
	output logic [7:0] tx_byte,
	output logic [7:0] result_value,
	output logic       failed,
	output logic [7:0] status_seen,
	output logic       last
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_START  = 3'd1,
		PH_ADDR_W = 3'd2,
		PH_REG    = 3'd3,
		PH_DATA   = 3'd4,
		PH_RSTART = 3'd5,
		PH_ADDR_R = 3'd6,
		PH_READ   = 3'd7
	} phase_t;

	// transaction state
	phase_t      phase_q;
	logic        write_mode_q;
	logic [7:0]  held_register_q;
	logic [7:0]  held_data_q;
	logic [7:0]  last_status_q;
	logic [7:0]  slave_address_q;

	// input register
	logic        valid_s1;
	logic        kind_s1;
	logic        write_not_read_s1;
	logic [7:0]  register_byte_s1;
	logic [7:0]  data_byte_s1;
	logic [7:0]  bus_status_s1;
	logic [7:0]  received_byte_s1;

	// result queue
	result_t             queue_q [OUT_DEPTH];
	logic [OUT_AW-1:0]   wr_ptr_q;
	logic [OUT_AW-1:0]   rd_ptr_q;
	logic [OUT_AW:0]     count_q;

	// next-state and result words for the word held in the input register
	phase_t      phase_d;
	logic [7:0]  last_status_d;
	logic        latch_request;
	logic [1:0]  push_n;
	result_t     res0;
	result_t     res1;
	logic [7:0]  masked;
	logic        fire;
	logic        pop;
	logic        in_take;

	// Consume the held word only when the queue can take both of its results.
	assign fire     = valid_s1 && (count_q <= (OUT_AW + 1)'(OUT_DEPTH - 2));
	assign in_ready = !valid_s1 || fire;
	assign in_take  = in_valid && in_ready;
	assign pop      = out_valid && out_ready;
	assign cfg_ready = 1'b1;

	assign masked = bus_status_s1 & STATUS_MASK;

	always_comb begin
		phase_d       = phase_q;
		last_status_d = last_status_q;
		latch_request = 1'b0;
		push_n        = 2'd0;
		res0          = '0;
		res1          = '0;
		if (kind_s1 == KIND_REQUEST) begin
			// accept a request only when idle; drop it otherwise
			if (phase_q == PH_IDLE) begin
				latch_request = 1'b1;
				last_status_d = 8'h00;
				phase_d       = PH_START;
				push_n        = 2'd1;
				res0.action   = ACT_START;
				res0.last     = 1'b1;
			end
		end else if (phase_q == PH_READ) begin
			// read completion: status is not examined
			phase_d             = PH_IDLE;
			push_n              = 2'd2;
			res0.action         = ACT_STOP;
			res1.action         = ACT_DONE;
			res1.result_value   = received_byte_s1;
			res1.last           = 1'b1;
		end else if (phase_q != PH_IDLE) begin
			last_status_d = masked;
			push_n        = 2'd1;
			res0.last     = 1'b1;
			// default outcome is a failure; each matching phase overrides it
			res0.action   = ACT_DONE;
			res0.failed   = 1'b1;
			phase_d       = PH_IDLE;
			case (phase_q)
				PH_START: begin
					if (masked == CODE_START) begin
						phase_d      = PH_ADDR_W;
						res0.action  = ACT_SEND;
						res0.failed  = 1'b0;
						res0.tx_byte = slave_address_q & ADDR_W_MASK;
					end
				end
				PH_ADDR_W: begin
					if (masked == CODE_AW_ACK) begin
						phase_d      = PH_REG;
						res0.action  = ACT_SEND;
						res0.failed  = 1'b0;
						res0.tx_byte = held_register_q;
					end
				end
				PH_REG: begin
					if (masked == CODE_B_ACK) begin
						res0.failed = 1'b0;
						if (write_mode_q) begin
							phase_d      = PH_DATA;
							res0.action  = ACT_SEND;
							res0.tx_byte = held_data_q;
						end else begin
							phase_d     = PH_RSTART;
							res0.action = ACT_START;
						end
					end
				end
				PH_DATA: begin
					if (masked == CODE_B_ACK) begin
						push_n            = 2'd2;
						res0.action       = ACT_STOP;
						res0.failed       = 1'b0;
						res0.last         = 1'b0;
						res1.action       = ACT_DONE;
						res1.result_value = WRITE_OK;
						res1.last         = 1'b1;
					end
				end
				PH_RSTART: begin
					if (masked == CODE_RSTART) begin
						phase_d      = PH_ADDR_R;
						res0.action  = ACT_SEND;
						res0.failed  = 1'b0;
						res0.tx_byte = slave_address_q | 8'h01;
					end
				end
				PH_ADDR_R: begin
					if (masked == CODE_AR_ACK) begin
						phase_d     = PH_READ;
						res0.action = ACT_READ;
						res0.failed = 1'b0;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					push_n  = 2'd0;
				end
			endcase
		end
		// both words of a pair report the updated status
		res0.status_seen = last_status_d;
		res1.status_seen = last_status_d;
	end

	// Control state and transaction registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			write_mode_q    <= 1'b0;
			held_register_q <= 8'h00;
			held_data_q     <= 8'h00;
			last_status_q   <= 8'h00;
			slave_address_q <= 8'h00;
			valid_s1        <= 1'b0;
			wr_ptr_q        <= '0;
			rd_ptr_q        <= '0;
			count_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				slave_address_q <= cfg_data;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				phase_q       <= phase_d;
				last_status_q <= last_status_d;
				if (latch_request) begin
					write_mode_q    <= write_not_read_s1;
					held_register_q <= register_byte_s1;
					held_data_q     <= data_byte_s1;
				end
				wr_ptr_q <= wr_ptr_q + OUT_AW'(fire ? push_n : 2'd0);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_AW'(1);
			end
			count_q <= count_q + (OUT_AW + 1)'(fire ? push_n : 2'd0)
				- (OUT_AW + 1)'(pop);
		end
	end

	// Payload registers: input stage and queue entries.
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1           <= kind;
			write_not_read_s1 <= write_not_read;
			register_byte_s1  <= register_byte;
			data_byte_s1      <= data_byte;
			bus_status_s1     <= bus_status;
			received_byte_s1  <= received_byte;
		end
		if (fire && push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (fire && push_n == 2'd2) begin
			queue_q[wr_ptr_q + OUT_AW'(1)] <= res1;
		end
	end

	// Head of the queue drives the result port.
	assign out_valid    = (count_q != '0);
	assign action       = queue_q[rd_ptr_q].action;
	assign tx_byte      = queue_q[rd_ptr_q].tx_byte;
	assign result_value = queue_q[rd_ptr_q].result_value;
	assign failed       = queue_q[rd_ptr_q].failed;
	assign status_seen  = queue_q[rd_ptr_q].status_seen;
	assign last         = queue_q[rd_ptr_q].last;

	// Queue never overfills.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (OUT_AW + 1)'(OUT_DEPTH))
		else $error("result queue overfilled");

	// Input is stalled only while a word waits in the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with empty input register");

	// A failure word is always a done word with zero value and ends its group.
	a_fail_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && failed) |-> (action == ACT_DONE && result_value == 8'h00 && last))
		else $error("malformed failure word");

	// A request leaves the sequencer waiting for the start status.
	a_req_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && latch_request) |=> (phase_q == PH_START && last_status_q == 8'h00))
		else $error("request did not start a transaction");

endmodule
